>>> rtl/sop_pkg.sv
`timescale 1ns / 1ps
// Package for the shape overlap test: shared constants and the pair tables
// that map two vector indices onto one dot product. Depends on nothing.
package sop_pkg;

    localparam int FIELD_W         = 32;
    localparam int COORD_WIDTH_DEF = 32;
    localparam int NVEC            = 5;
    localparam int NPAIR           = 15;
    localparam int NLANE           = 3;

    // Vector numbering: left u, left v, right u, right v, centre offset.
    localparam int VEC_LU = 0;
    localparam int VEC_LV = 1;
    localparam int VEC_RU = 2;
    localparam int VEC_RV = 3;
    localparam int VEC_C  = 4;

    // Dot product slot for vector pair (i, j), indexed by i * NVEC + j.
    localparam int PIDX [25] = '{
        0, 1, 2, 3, 4,
        1, 5, 6, 7, 8,
        2, 6, 9, 10, 11,
        3, 7, 10, 12, 13,
        4, 8, 11, 13, 14
    };

    // First and second vector of each dot product slot.
    localparam int PA [NPAIR] = '{0, 0, 0, 0, 0, 1, 1, 1, 1, 2, 2, 2, 3, 3, 4};
    localparam int PB [NPAIR] = '{0, 1, 2, 3, 4, 1, 2, 3, 4, 2, 3, 4, 3, 4, 4};

    // Rectangle against circle, per orientation (0: left rectangle, 1: right).
    localparam int ORI_RU [2] = '{VEC_LU, VEC_RU};
    localparam int ORI_RV [2] = '{VEC_LV, VEC_RV};
    localparam int ORI_CU [2] = '{VEC_RU, VEC_LU};

endpackage

>>> rtl/shape_overlap_test.sv
`timescale 1ns / 1ps
// Top level of the shape overlap test: a pipelined separating-axis and
// circle distance check on two 2D shapes. Depends on sop_pkg.
//
// Usage: drive the ten coordinate fields and the two shape kind bits and
// raise start for one cycle per transaction. busy is always low, so a new
// transaction is taken at every clock edge at which start is high.
// Each transaction gives exactly one result: o_overlapping, shown for one
// cycle while o_valid is high, once it has passed the register stages.
// Throughput is one transaction per cycle; the nine register stages are
// input capture, products, dot sums, magnitudes, axis extents, compares and
// operand setup, split partial products, product sums and the final compare.
// Only the low COORD_WIDTH bits of each coordinate are used.
// A synchronous reset on i_rst_n clears all valid bits, so no result comes
// out of transactions in flight. The receiver cannot stall the block: a
// result is taken at the edge that ends its valid cycle.
module shape_overlap_test #(
    parameter int COORD_WIDTH = sop_pkg::COORD_WIDTH_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               start,
    output logic                               busy,
    input  logic signed [sop_pkg::FIELD_W-1:0] i_left_edge_u_x,
    input  logic signed [sop_pkg::FIELD_W-1:0] i_left_edge_u_y,
    input  logic signed [sop_pkg::FIELD_W-1:0] i_left_edge_v_x,
    input  logic signed [sop_pkg::FIELD_W-1:0] i_left_edge_v_y,
    input  logic signed [sop_pkg::FIELD_W-1:0] i_right_edge_u_x,
    input  logic signed [sop_pkg::FIELD_W-1:0] i_right_edge_u_y,
    input  logic signed [sop_pkg::FIELD_W-1:0] i_right_edge_v_x,
    input  logic signed [sop_pkg::FIELD_W-1:0] i_right_edge_v_y,
    input  logic signed [sop_pkg::FIELD_W-1:0] i_centre_dx,
    input  logic signed [sop_pkg::FIELD_W-1:0] i_centre_dy,
    input  logic                               i_left_is_circle,
    input  logic                               i_right_is_circle,
    output logic                               o_valid,
    output logic                               o_overlapping
);
    import sop_pkg::*;

    localparam int W  = COORD_WIDTH;
    localparam int DW = 2 * W + 1;
    localparam int SW = DW + 2;
    localparam int M  = DW + 2;
    localparam int H  = (M + 1) / 2;
    localparam int PW = 4 * H;

    logic [8:0] r_vld;
    logic [8:0] r_lc;
    logic [8:0] r_rc;

    logic signed [W-1:0]    r_vx [NVEC];
    logic signed [W-1:0]    r_vy [NVEC];
    logic signed [2*W-1:0]  r_px [NPAIR];
    logic signed [2*W-1:0]  r_py [NPAIR];
    logic signed [DW-1:0]   r_dot [NPAIR];
    logic [DW-1:0]          r_mag [NPAIR];

    logic [SW-1:0]          n_s [4];
    logic [DW:0]            n_t [4];
    logic signed [M-1:0]    n_qo [2][NLANE];
    logic signed [M-1:0]    n_q [NLANE];
    logic [DW-1:0]          n_aa [NLANE];
    logic [DW-1:0]          n_ww;
    logic [SW-1:0]          r_s [4];
    logic [DW:0]            r_t [4];
    logic signed [M-1:0]    r_q [NLANE];
    logic [DW-1:0]          r_aa [NLANE];
    logic [DW-1:0]          r_ww;
    logic [M-1:0]           r_c4;
    logic [M-1:0]           r_sab;
    logic [DW-1:0]          r_ca;
    logic [DW-1:0]          r_cb;

    logic                   n_rrsep;
    logic [NLANE-1:0]       n_act;
    logic [M-1:0]           n_opa [NLANE];
    logic [M-1:0]           n_opb [NLANE];
    logic [M-1:0]           n_opc [NLANE];
    logic                   r_rrsep6;
    logic                   r_early6;
    logic [NLANE-1:0]       r_act6;
    logic [M-1:0]           r_opa [NLANE];
    logic [M-1:0]           r_opb [NLANE];
    logic [M-1:0]           r_opc [NLANE];

    logic [2*H-1:0]         r_abll [NLANE];
    logic [2*H-1:0]         r_ablh [NLANE];
    logic [2*H-1:0]         r_abhl [NLANE];
    logic [2*H-1:0]         r_abhh [NLANE];
    logic [2*H-1:0]         r_ccll [NLANE];
    logic [2*H-1:0]         r_cclh [NLANE];
    logic [2*H-1:0]         r_cchh [NLANE];
    logic                   r_rrsep7;
    logic                   r_early7;
    logic [NLANE-1:0]       r_act7;

    logic [PW-1:0]          r_ab [NLANE];
    logic [PW-1:0]          r_cc [NLANE];
    logic                   r_rrsep8;
    logic                   r_early8;
    logic [NLANE-1:0]       r_act8;

    logic [NLANE-1:0]       n_lt;
    logic                   n_hit;
    logic                   r_hit;

    assign busy = 1'b0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= {r_vld[7:0], start};
        end
    end

    always_ff @(posedge i_clk) begin
        r_lc <= {r_lc[7:0], i_left_is_circle};
        r_rc <= {r_rc[7:0], i_right_is_circle};
    end

    // Stage 1: coordinates cut to the working width.
    always_ff @(posedge i_clk) begin
        r_vx[VEC_LU] <= i_left_edge_u_x[W-1:0];
        r_vy[VEC_LU] <= i_left_edge_u_y[W-1:0];
        r_vx[VEC_LV] <= i_left_edge_v_x[W-1:0];
        r_vy[VEC_LV] <= i_left_edge_v_y[W-1:0];
        r_vx[VEC_RU] <= i_right_edge_u_x[W-1:0];
        r_vy[VEC_RU] <= i_right_edge_u_y[W-1:0];
        r_vx[VEC_RV] <= i_right_edge_v_x[W-1:0];
        r_vy[VEC_RV] <= i_right_edge_v_y[W-1:0];
        r_vx[VEC_C]  <= i_centre_dx[W-1:0];
        r_vy[VEC_C]  <= i_centre_dy[W-1:0];
    end

    // Stages 2 to 4: component products, dot products, magnitudes.
    always_ff @(posedge i_clk) begin
        for (int p = 0; p < NPAIR; p++) begin
            r_px[p]  <= r_vx[PA[p]] * r_vx[PB[p]];
            r_py[p]  <= r_vy[PA[p]] * r_vy[PB[p]];
            r_dot[p] <= DW'(r_px[p]) + DW'(r_py[p]);
            r_mag[p] <= r_dot[p][DW-1] ? DW'(-r_dot[p]) : DW'(r_dot[p]);
        end
    end

    // Stage 5: projected extents for every test.
    always_comb begin
        for (int i = 0; i < 4; i++) begin
            n_s[i] = '0;
            for (int j = 0; j < 4; j++) begin
                n_s[i] = n_s[i] + SW'(r_mag[PIDX[i*NVEC+j]]);
            end
            n_t[i] = {r_mag[PIDX[i*NVEC+VEC_C]], 1'b0};
        end
        for (int o = 0; o < 2; o++) begin
            n_qo[o][0] = M'({r_mag[PIDX[ORI_RU[o]*NVEC+VEC_C]], 1'b0})
                       - M'(r_mag[PIDX[ORI_RU[o]*NVEC+ORI_RU[o]]])
                       - M'(r_mag[PIDX[ORI_RU[o]*NVEC+ORI_RV[o]]]);
            n_qo[o][1] = M'({r_mag[PIDX[ORI_RV[o]*NVEC+VEC_C]], 1'b0})
                       - M'(r_mag[PIDX[ORI_RV[o]*NVEC+ORI_RU[o]]])
                       - M'(r_mag[PIDX[ORI_RV[o]*NVEC+ORI_RV[o]]]);
            n_qo[o][2] = M'({r_mag[PIDX[VEC_C*NVEC+VEC_C]], 1'b0})
                       - M'(r_mag[PIDX[VEC_C*NVEC+ORI_RU[o]]])
                       - M'(r_mag[PIDX[VEC_C*NVEC+ORI_RV[o]]]);
        end
        for (int k = 0; k < NLANE; k++) begin
            n_q[k] = r_lc[3] ? n_qo[1][k] : n_qo[0][k];
        end
        n_aa[0] = r_lc[3] ? r_mag[PIDX[VEC_RU*NVEC+VEC_RU]] : r_mag[PIDX[VEC_LU*NVEC+VEC_LU]];
        n_aa[1] = r_lc[3] ? r_mag[PIDX[VEC_RV*NVEC+VEC_RV]] : r_mag[PIDX[VEC_LV*NVEC+VEC_LV]];
        n_aa[2] = r_mag[PIDX[VEC_C*NVEC+VEC_C]];
        n_ww    = r_lc[3] ? r_mag[PIDX[ORI_CU[1]*NVEC+ORI_CU[1]]]
                          : r_mag[PIDX[ORI_CU[0]*NVEC+ORI_CU[0]]];
    end

    always_ff @(posedge i_clk) begin
        r_s   <= n_s;
        r_t   <= n_t;
        r_q   <= n_q;
        r_aa  <= n_aa;
        r_ww  <= n_ww;
        r_c4  <= {r_mag[PIDX[VEC_C*NVEC+VEC_C]], 2'b00};
        r_sab <= M'(r_mag[PIDX[VEC_LU*NVEC+VEC_LU]]) + M'(r_mag[PIDX[VEC_RU*NVEC+VEC_RU]]);
        r_ca  <= r_mag[PIDX[VEC_LU*NVEC+VEC_LU]];
        r_cb  <= r_mag[PIDX[VEC_RU*NVEC+VEC_RU]];
    end

    // Stage 6: rectangle compares and operands of the squared compares.
    always_comb begin
        n_rrsep = 1'b0;
        for (int i = 0; i < 4; i++) begin
            n_rrsep = n_rrsep | (r_s[i] < SW'(r_t[i]));
        end
        for (int k = 0; k < NLANE; k++) begin
            n_act[k] = !r_q[k][M-1] && (r_q[k] != '0);
            if (r_lc[4] && r_rc[4]) begin
                n_opa[k] = {r_ca, 2'b00};
                n_opb[k] = M'(r_cb);
                n_opc[k] = r_c4 - r_sab;
            end else begin
                n_opa[k] = M'(r_ww);
                n_opb[k] = M'(r_aa[k]);
                n_opc[k] = n_act[k] ? r_q[k] : '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_rrsep6 <= n_rrsep;
        r_early6 <= r_c4 <= r_sab;
        r_act6   <= n_act;
        r_opa    <= n_opa;
        r_opb    <= n_opb;
        r_opc    <= n_opc;
    end

    // Stage 7: half-width partial products.
    always_ff @(posedge i_clk) begin
        for (int k = 0; k < NLANE; k++) begin
            r_abll[k] <= (2*H)'(r_opa[k][H-1:0]) * (2*H)'(r_opb[k][H-1:0]);
            r_ablh[k] <= (2*H)'(r_opa[k][H-1:0]) * (2*H)'(r_opb[k][M-1:H]);
            r_abhl[k] <= (2*H)'(r_opa[k][M-1:H]) * (2*H)'(r_opb[k][H-1:0]);
            r_abhh[k] <= (2*H)'(r_opa[k][M-1:H]) * (2*H)'(r_opb[k][M-1:H]);
            r_ccll[k] <= (2*H)'(r_opc[k][H-1:0]) * (2*H)'(r_opc[k][H-1:0]);
            r_cclh[k] <= (2*H)'(r_opc[k][H-1:0]) * (2*H)'(r_opc[k][M-1:H]);
            r_cchh[k] <= (2*H)'(r_opc[k][M-1:H]) * (2*H)'(r_opc[k][M-1:H]);
        end
        r_rrsep7 <= r_rrsep6;
        r_early7 <= r_early6;
        r_act7   <= r_act6;
    end

    // Stage 8: full products.
    always_ff @(posedge i_clk) begin
        for (int k = 0; k < NLANE; k++) begin
            r_ab[k] <= (PW'(r_abhh[k]) << (2*H))
                     + ((PW'(r_ablh[k]) + PW'(r_abhl[k])) << H)
                     + PW'(r_abll[k]);
            r_cc[k] <= (PW'(r_cchh[k]) << (2*H))
                     + (PW'(r_cclh[k]) << (H + 1))
                     + PW'(r_ccll[k]);
        end
        r_rrsep8 <= r_rrsep7;
        r_early8 <= r_early7;
        r_act8   <= r_act7;
    end

    // Stage 9: final decision per shape combination.
    always_comb begin
        for (int k = 0; k < NLANE; k++) begin
            n_lt[k] = r_ab[k] < r_cc[k];
        end
        if (!r_lc[7] && !r_rc[7]) begin
            n_hit = !r_rrsep8;
        end else if (r_lc[7] && r_rc[7]) begin
            n_hit = r_early8 || !n_lt[0];
        end else begin
            n_hit = !(|(r_act8 & n_lt));
        end
    end

    always_ff @(posedge i_clk) begin
        r_hit <= n_hit;
    end

    assign o_valid       = r_vld[8];
    assign o_overlapping = r_hit;

endmodule
